>>> rtl/core/ray_rect_intersection_core_defines.svh
// Assertion macros for the ray/rectangle intersection core.
`ifndef RAY_RECT_INTERSECTION_CORE_DEFINES_SVH
`define RAY_RECT_INTERSECTION_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define RRI_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rri assertion failed");

// next-cycle implication, disabled in reset
`define RRI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rri assertion failed");

`endif

>>> rtl/core/rri_pkg.sv
// Shared types, widths and helpers for the ray/rectangle intersection core.
`default_nettype none
package rri_pkg;
  localparam int COORD_WIDTH = 20;
  localparam int FRAC_BITS   = 10;
  localparam int CFG_IDX_W   = 3;
  localparam int VEC_W       = 3 * COORD_WIDTH;
  localparam int DEN_W       = 2 * COORD_WIDTH + 2;
  localparam int NUM_W       = 2 * COORD_WIDTH + 3;
  localparam int PROD_W      = 3 * COORD_WIDTH + 3;
  localparam int QUOT_BITS   = COORD_WIDTH + 1;
  localparam int QUO_W       = QUOT_BITS + 1;
  localparam int DIV_LAT     = QUOT_BITS + 2;
  localparam int PIPE_LAT    = 4 + DIV_LAT + 3;
  localparam int SAT_W       = 3 * COORD_WIDTH + 4;

  localparam logic signed [SAT_W-1:0] SAT_MAX =
    SAT_W'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
  localparam logic signed [SAT_W-1:0] SAT_MIN = -SAT_MAX - SAT_W'(1);

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic [COORD_WIDTH-2:0]        extent_t;
  typedef logic [CFG_IDX_W-1:0]          cfg_idx_t;

  localparam cfg_idx_t REG_CENTER = CFG_IDX_W'(0);
  localparam cfg_idx_t REG_ACROSS = CFG_IDX_W'(1);
  localparam cfg_idx_t REG_UP     = CFG_IDX_W'(2);
  localparam cfg_idx_t REG_WIDTH  = CFG_IDX_W'(3);
  localparam cfg_idx_t REG_HEIGHT = CFG_IDX_W'(4);

  typedef enum logic [1:0] {
    ST_HIT      = 2'd0,
    ST_PARALLEL = 2'd1,
    ST_BEHIND   = 2'd2,
    ST_OUTSIDE  = 2'd3
  } status_t;

  typedef struct packed {
    coord_t z;
    coord_t y;
    coord_t x;
  } vec_t;

  typedef struct packed {
    vec_t    center;
    vec_t    across;
    vec_t    up;
    extent_t width;
    extent_t height;
  } rect_cfg_t;

  typedef struct packed {
    coord_t origin_x;
    coord_t origin_y;
    coord_t origin_z;
    coord_t direction_x;
    coord_t direction_y;
    coord_t direction_z;
  } in_beat_t;

  typedef struct packed {
    logic    hit;
    status_t status;
    coord_t  hit_x;
    coord_t  hit_y;
    coord_t  hit_z;
  } out_beat_t;

  typedef struct packed {
    logic vld;
    logic par;
    logic beh;
  } side_t;

  function automatic coord_t sat_coord(input logic signed [SAT_W-1:0] v);
    coord_t r;
    if (v > SAT_MAX) begin
      r = SAT_MAX[COORD_WIDTH-1:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[COORD_WIDTH-1:0];
    end else begin
      r = v[COORD_WIDTH-1:0];
    end
    return r;
  endfunction
endpackage
`default_nettype wire

>>> rtl/core/rri_div.sv
// Pipelined restoring divider lane, one quotient bit per stage, truncating.
`default_nettype none
module rri_div (
  input  logic                                clk,
  input  logic signed [rri_pkg::PROD_W-1:0]   num,
  input  logic signed [rri_pkg::DEN_W-1:0]    den,
  input  rri_pkg::coord_t                     tag,
  output logic signed [rri_pkg::QUO_W-1:0]    quo,
  output rri_pkg::coord_t                     tag_o
);
  localparam int PW = rri_pkg::PROD_W;
  localparam int QB = rri_pkg::QUOT_BITS;
  localparam int QW = rri_pkg::QUO_W;

  logic signed [PW-1:0] den_x;
  logic [PW-1:0]        r_nxt, d_nxt;
  logic                 ovf_nxt;

  logic [PW-1:0]        r_r   [0:QB];
  logic [PW-1:0]        d_r   [0:QB];
  logic [QB-1:0]        qa_r  [0:QB];
  logic                 neg_r [0:QB];
  logic                 ovf_r [0:QB];
  rri_pkg::coord_t      tag_r [0:QB];
  logic [PW-1:0]        sh    [1:QB];
  logic                 ge    [1:QB];
  logic [QB-1:0]        mag;
  logic signed [QW-1:0] quo_r;
  rri_pkg::coord_t      tag_o_r;

  assign den_x   = PW'(den);
  assign r_nxt   = num[PW-1] ? PW'(-num) : PW'(num);
  assign d_nxt   = den_x[PW-1] ? PW'(-den_x) : PW'(den_x);
  assign ovf_nxt = r_nxt >= (d_nxt << QB);

  always_comb begin
    for (int s = 1; s <= QB; s++) begin
      sh[s] = d_r[s-1] << (QB - s);
      ge[s] = r_r[s-1] >= sh[s];
    end
  end

  assign mag = ovf_r[QB] ? '1 : qa_r[QB];

  always_ff @(posedge clk) begin
    r_r[0]   <= r_nxt;
    d_r[0]   <= d_nxt;
    qa_r[0]  <= '0;
    neg_r[0] <= num[PW-1] ^ den[rri_pkg::DEN_W-1];
    ovf_r[0] <= ovf_nxt;
    tag_r[0] <= tag;
    for (int s = 1; s <= QB; s++) begin
      r_r[s]   <= ge[s] ? r_r[s-1] - sh[s] : r_r[s-1];
      d_r[s]   <= d_r[s-1];
      qa_r[s]  <= qa_r[s-1] | (ge[s] ? (QB'(1) << (QB - s)) : '0);
      neg_r[s] <= neg_r[s-1];
      ovf_r[s] <= ovf_r[s-1];
      tag_r[s] <= tag_r[s-1];
    end
    quo_r   <= neg_r[QB] ? -$signed(QW'(mag)) : $signed(QW'(mag));
    tag_o_r <= tag_r[QB];
  end

  assign quo   = quo_r;
  assign tag_o = tag_o_r;
endmodule
`default_nettype wire

>>> rtl/core/rri_front.sv
// Front pipeline: plane normal, numerator, denominator and offset products.
`default_nettype none
module rri_front #(
  parameter int FRAC_BITS = rri_pkg::FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  rri_pkg::in_beat_t                 in_data,
  input  rri_pkg::rect_cfg_t                cfg,
  output rri_pkg::side_t                    side,
  output logic signed [rri_pkg::PROD_W-1:0] prod [3],
  output logic signed [rri_pkg::DEN_W-1:0]  den,
  output rri_pkg::coord_t                   orig [3]
);
  localparam int W  = rri_pkg::COORD_WIDTH;
  localparam int DW = rri_pkg::DEN_W;
  localparam int NW = rri_pkg::NUM_W;
  localparam int PW = rri_pkg::PROD_W;

  rri_pkg::coord_t a [3], u [3], c [3], oi [3], di [3];

  assign a[0]  = cfg.across.x;  assign a[1]  = cfg.across.y;  assign a[2]  = cfg.across.z;
  assign u[0]  = cfg.up.x;      assign u[1]  = cfg.up.y;      assign u[2]  = cfg.up.z;
  assign c[0]  = cfg.center.x;  assign c[1]  = cfg.center.y;  assign c[2]  = cfg.center.z;
  assign oi[0] = in_data.origin_x;    assign oi[1] = in_data.origin_y;
  assign oi[2] = in_data.origin_z;
  assign di[0] = in_data.direction_x; assign di[1] = in_data.direction_y;
  assign di[2] = in_data.direction_z;

  // stage 1: cross-product terms, center minus origin
  logic signed [2*W-1:0] cp_nxt [6], cp_r [6];
  logic signed [W:0]     co_nxt [3], co_r [3];
  rri_pkg::coord_t       d1_r [3], o1_r [3];
  logic                  v1_r;

  always_comb begin
    cp_nxt[0] = a[1] * u[2];
    cp_nxt[1] = a[2] * u[1];
    cp_nxt[2] = a[2] * u[0];
    cp_nxt[3] = a[0] * u[2];
    cp_nxt[4] = a[0] * u[1];
    cp_nxt[5] = a[1] * u[0];
    for (int k = 0; k < 3; k++) begin
      co_nxt[k] = c[k] - oi[k];
    end
  end

  // stage 2: saturated normal, dot-product terms
  logic signed [2*W:0]   diff [3];
  rri_pkg::coord_t       nrm [3];
  logic signed [2*W-1:0] dn_nxt [3], dn_r [3];
  logic signed [2*W:0]   cn_nxt [3], cn_r [3];
  rri_pkg::coord_t       d2_r [3], o2_r [3];
  logic                  v2_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k]   = cp_r[2*k] - cp_r[2*k+1];
      nrm[k]    = rri_pkg::sat_coord(rri_pkg::SAT_W'(diff[k] >>> FRAC_BITS));
      dn_nxt[k] = d1_r[k] * nrm[k];
      cn_nxt[k] = co_r[k] * nrm[k];
    end
  end

  // stage 3: sums
  logic signed [DW-1:0] den_nxt, den3_r;
  logic signed [NW-1:0] num_nxt, num3_r;
  rri_pkg::coord_t      d3_r [3], o3_r [3];
  logic                 v3_r;

  assign den_nxt = DW'(dn_r[0]) + DW'(dn_r[1]) + DW'(dn_r[2]);
  assign num_nxt = NW'(cn_r[0]) + NW'(cn_r[1]) + NW'(cn_r[2]);

  // stage 4: numerator times direction, miss flags
  logic signed [PW-1:0] prod_nxt [3], prod_r [3];
  logic signed [DW-1:0] den4_r;
  rri_pkg::coord_t      o4_r [3];
  rri_pkg::side_t       side_nxt, side_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod_nxt[k] = num3_r * d3_r[k];
    end
    side_nxt.vld = v3_r;
    side_nxt.par = den3_r == '0;
    side_nxt.beh = (num3_r != '0) && (num3_r[NW-1] != den3_r[DW-1]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      side_r <= '0;
    end else begin
      v1_r   <= in_valid;
      v2_r   <= v1_r;
      v3_r   <= v2_r;
      side_r <= side_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cp_r   <= cp_nxt;
    co_r   <= co_nxt;
    d1_r   <= di;
    o1_r   <= oi;
    dn_r   <= dn_nxt;
    cn_r   <= cn_nxt;
    d2_r   <= d1_r;
    o2_r   <= o1_r;
    den3_r <= den_nxt;
    num3_r <= num_nxt;
    d3_r   <= d2_r;
    o3_r   <= o2_r;
    prod_r <= prod_nxt;
    den4_r <= den3_r;
    o4_r   <= o3_r;
  end

  assign side = side_r;
  assign prod = prod_r;
  assign den  = den4_r;
  assign orig = o4_r;
endmodule
`default_nettype wire

>>> rtl/core/rri_back.sv
// Back pipeline: saturated hit point, rectangle bounds test, result register.
`default_nettype none
module rri_back #(
  parameter int FRAC_BITS = rri_pkg::FRAC_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  rri_pkg::side_t                   side,
  input  logic signed [rri_pkg::QUO_W-1:0] quo [3],
  input  rri_pkg::coord_t                  orig [3],
  input  rri_pkg::rect_cfg_t               cfg,
  output logic                             out_valid,
  output rri_pkg::out_beat_t               out_data
);
  localparam int W    = rri_pkg::COORD_WIDTH;
  localparam int SW   = 2 * W + 3;
  localparam int CMPW = 2 * W + FRAC_BITS + 4;

  rri_pkg::coord_t a [3], u [3], c [3];
  assign a[0] = cfg.across.x;  assign a[1] = cfg.across.y;  assign a[2] = cfg.across.z;
  assign u[0] = cfg.up.x;      assign u[1] = cfg.up.y;      assign u[2] = cfg.up.z;
  assign c[0] = cfg.center.x;  assign c[1] = cfg.center.y;  assign c[2] = cfg.center.z;

  // stage 1: hit point and offset from center
  rri_pkg::coord_t   h_nxt [3], h1_r [3], h2_r [3];
  logic signed [W:0] p_nxt [3], p1_r [3];
  rri_pkg::side_t    s1_r, s2_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      h_nxt[k] = rri_pkg::sat_coord(rri_pkg::SAT_W'(orig[k]) + rri_pkg::SAT_W'(quo[k]));
      p_nxt[k] = h_nxt[k] - c[k];
    end
  end

  // stage 2: axis products
  logic signed [2*W:0] pa_nxt [3], pa_r [3], pu_nxt [3], pu_r [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pa_nxt[k] = p1_r[k] * a[k];
      pu_nxt[k] = p1_r[k] * u[k];
    end
  end

  // stage 3: doubled sums against the half extents
  logic signed [SW-1:0]   sa, su;
  logic signed [CMPW-1:0] sa2, su2, wl, hl;
  logic                   in_rect;
  rri_pkg::out_beat_t     out_nxt, out_r;
  logic                   ov_r;

  assign sa      = SW'(pa_r[0]) + SW'(pa_r[1]) + SW'(pa_r[2]);
  assign su      = SW'(pu_r[0]) + SW'(pu_r[1]) + SW'(pu_r[2]);
  assign sa2     = CMPW'(sa) <<< 1;
  assign su2     = CMPW'(su) <<< 1;
  assign wl      = $signed(CMPW'(cfg.width)) <<< FRAC_BITS;
  assign hl      = $signed(CMPW'(cfg.height)) <<< FRAC_BITS;
  assign in_rect = (sa2 >= -wl) && (sa2 <= wl) && (su2 >= -hl) && (su2 <= hl);

  always_comb begin
    out_nxt = '0;
    priority if (s2_r.par) begin
      out_nxt.status = rri_pkg::ST_PARALLEL;
    end else if (s2_r.beh) begin
      out_nxt.status = rri_pkg::ST_BEHIND;
    end else begin
      out_nxt.hit    = in_rect;
      out_nxt.status = in_rect ? rri_pkg::ST_HIT : rri_pkg::ST_OUTSIDE;
      out_nxt.hit_x  = h2_r[0];
      out_nxt.hit_y  = h2_r[1];
      out_nxt.hit_z  = h2_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0;
      s2_r <= '0;
      ov_r <= 1'b0;
    end else begin
      s1_r <= side;
      s2_r <= s1_r;
      ov_r <= s2_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    h1_r  <= h_nxt;
    p1_r  <= p_nxt;
    h2_r  <= h1_r;
    pa_r  <= pa_nxt;
    pu_r  <= pu_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = ov_r;
  assign out_data  = out_r;
endmodule
`default_nettype wire

>>> rtl/core/ray_rect_intersection_core.sv
// Top level of the ray/rectangle intersection core.
// One ray is taken on every cycle that start is high (busy stays low), and its
// result appears on out_data with out_valid high for one cycle, after it has passed
// through the front stages, the divider lanes and the back stages; results come out in
// order and cannot be held off. Most of the pipeline lies in the three parallel
// restoring divider lanes, one quotient bit per stage over COORD_WIDTH + 1 stages.
// Rectangle registers are written through cfg_* at any time cfg_ready is high;
// write them only while no ray is in flight.
`default_nettype none
module ray_rect_intersection_core #(
  parameter int FRAC_BITS = rri_pkg::FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  rri_pkg::in_beat_t             in_data,
  output logic                          out_valid,
  output rri_pkg::out_beat_t            out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  rri_pkg::cfg_idx_t             cfg_index,
  input  logic [rri_pkg::VEC_W-1:0]     cfg_data
);
  localparam int W  = rri_pkg::COORD_WIDTH;
  localparam int DL = rri_pkg::DIV_LAT;

  rri_pkg::rect_cfg_t cfg_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rri_pkg::REG_CENTER: cfg_r.center <= rri_pkg::vec_t'(cfg_data);
        rri_pkg::REG_ACROSS: cfg_r.across <= rri_pkg::vec_t'(cfg_data);
        rri_pkg::REG_UP:     cfg_r.up     <= rri_pkg::vec_t'(cfg_data);
        rri_pkg::REG_WIDTH:  cfg_r.width  <= cfg_data[W-2:0];
        rri_pkg::REG_HEIGHT: cfg_r.height <= cfg_data[W-2:0];
        default: ;
      endcase
    end
  end

  rri_pkg::side_t                    f_side;
  logic signed [rri_pkg::PROD_W-1:0] f_prod [3];
  logic signed [rri_pkg::DEN_W-1:0]  f_den;
  rri_pkg::coord_t                   f_orig [3];

  rri_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start && !busy),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .side     (f_side),
    .prod     (f_prod),
    .den      (f_den),
    .orig     (f_orig)
  );

  logic signed [rri_pkg::QUO_W-1:0] d_quo [3];
  rri_pkg::coord_t                  d_orig [3];

  for (genvar k = 0; k < 3; k++) begin : g_lane
    rri_div u_div (
      .clk   (clk),
      .num   (f_prod[k]),
      .den   (f_den),
      .tag   (f_orig[k]),
      .quo   (d_quo[k]),
      .tag_o (d_orig[k])
    );
  end

  // valid and miss flags ride alongside the divider lanes
  rri_pkg::side_t side_dly_r [DL];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DL; i++) begin
        side_dly_r[i] <= '0;
      end
    end else begin
      side_dly_r[0] <= f_side;
      for (int i = 1; i < DL; i++) begin
        side_dly_r[i] <= side_dly_r[i-1];
      end
    end
  end

  rri_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .side      (side_dly_r[DL-1]),
    .quo       (d_quo),
    .orig      (d_orig),
    .cfg       (cfg_r),
    .out_valid (out_valid),
    .out_data  (out_data)
  );
endmodule
`default_nettype wire

>>> rtl/core/rri_checker.sv
// Port-level assertion checker for the intersection core, bound to the top level.
`default_nettype none
`include "ray_rect_intersection_core_defines.svh"
module rri_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      start,
  input logic                      busy,
  input logic                      out_valid,
  input rri_pkg::out_beat_t        out_data,
  input logic                      cfg_valid,
  input logic                      cfg_ready
);
  `RRI_ASSERT_IMPL(a_out_follows_beat, out_valid, $past(start && !busy, rri_pkg::PIPE_LAT))
  `RRI_ASSERT_IMPL(a_hit_matches_status, out_valid, out_data.hit == (out_data.status == rri_pkg::ST_HIT))
  `RRI_ASSERT_IMPL(a_miss_zero_point, out_valid && (out_data.status == rri_pkg::ST_PARALLEL || out_data.status == rri_pkg::ST_BEHIND), out_data.hit_x == '0 && out_data.hit_y == '0 && out_data.hit_z == '0)
  `RRI_ASSERT_NEXT(a_cfg_always_ready, cfg_valid, cfg_ready)
endmodule

bind ray_rect_intersection_core rri_checker u_rri_checker (.*);
`default_nettype wire
